### rtl/bupd_pkg.sv
package bupd_pkg;

  // register indexes on the config port
  localparam int REG_FRAME_WIDTH  = 0;
  localparam int REG_FRAME_HEIGHT = 1;

  localparam int FRAME_W_RESET = 640;
  localparam int FRAME_H_RESET = 480;
  localparam int FRAME_W_MIN   = 640;
  localparam int FRAME_H_MIN   = 480;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_TRUNC = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [12:0] pixel_x;
    logic [12:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        dirty_valid;
    logic [13:0] dirty_left;
    logic [13:0] dirty_top;
    logic [13:0] dirty_right;
    logic [13:0] dirty_bottom;
    logic        end_of_run;
  } res_t;

  // results caused by one byte: an optional pixel write, then an optional end report
  typedef struct packed {
    logic pix_vld;
    res_t pix;
    logic fin_vld;
    res_t fin;
  } res_pair_t;

  // floor(x * 255 / 31)
  localparam logic [7:0] SCALE5 [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  function automatic logic [7:0] scale5(input logic [4:0] x);
    return SCALE5[x];
  endfunction

  // floor(x * 255 / 63) = 4x + floor(x / 21)
  function automatic logic [7:0] scale6(input logic [5:0] x);
    logic [1:0] inc;
    if (x == 6'd63)       inc = 2'd3;
    else if (x >= 6'd42)  inc = 2'd2;
    else if (x >= 6'd21)  inc = 2'd1;
    else                  inc = 2'd0;
    return {x, 2'b00} + 8'(inc);
  endfunction

endpackage

### rtl/bupd_parser.sv
module bupd_parser import bupd_pkg::*; #(
  parameter int MAX_FRAME_DIM = 8192,
  localparam int DimW = $clog2(MAX_FRAME_DIM + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            acc_i,
  input  logic [7:0]      data_byte_i,
  input  logic            final_byte_i,
  input  logic [DimW-1:0] frame_w_i,
  input  logic [DimW-1:0] frame_h_i,
  output res_pair_t       res_o
);

  typedef enum logic [1:0] {
    PH_COUNT,
    PH_HEADER,
    PH_BITMAP,
    PH_DONE
  } phase_e;

  localparam int NWords   = 9;
  localparam int HdrLast  = 2 * NWords - 1;
  localparam int WLeft    = 0;
  localparam int WTop     = 1;
  localparam int WWidth   = 4;
  localparam int WHeight  = 5;
  localparam int WBpp     = 6;
  localparam int WFlags   = 7;
  localparam int WLength  = 8;

  phase_e            phase_q, phase_d;
  logic [15:0]       rects_q, rects_d;
  logic [15:0]       hdr_q [NWords];
  logic [15:0]       hdr_d [NWords];
  logic [4:0]        hidx_q, hidx_d;
  logic [15:0]       left_q, left_d;
  logic [15:0]       col_q, col_d;
  logic [15:0]       row_q, row_d;
  logic [23:0]       asm_q, asm_d;
  logic [1:0]        pbc_q, pbc_d;
  logic [DimW-1:0]   bnd_q [4];
  logic [DimW-1:0]   bnd_d [4];
  logic              seen_q, seen_d;

  logic [2:0]        bpp_bytes;
  logic [16:0]       sum_x, sum_y;
  logic              rect_ok;
  logic [3:0]        wi;
  logic [15:0]       len_new;
  logic [23:0]       asm_new;
  logic              do_finish;
  logic [15:0]       rects_dec;
  logic [DimW-1:0]   rl, rt, rr, rb;
  logic [15:0]       pix_v;

  always_comb begin
    case (hdr_q[WBpp])
      16'd16:  bpp_bytes = 3'd2;
      16'd24:  bpp_bytes = 3'd3;
      16'd32:  bpp_bytes = 3'd4;
      default: bpp_bytes = 3'd0;
    endcase
  end

  assign sum_x   = {1'b0, hdr_q[WLeft]} + {1'b0, hdr_q[WWidth]};
  assign sum_y   = {1'b0, hdr_q[WTop]} + {1'b0, hdr_q[WHeight]};
  assign rect_ok = !hdr_q[WFlags][0] && (bpp_bytes != 3'd0) &&
                   (sum_x <= 17'(frame_w_i)) && (sum_y <= 17'(frame_h_i));

  // bounds of the current rectangle, narrow since an accepted one fits the frame
  assign rl = DimW'(hdr_q[WLeft]);
  assign rt = DimW'(hdr_q[WTop]);
  assign rr = DimW'(sum_x);
  assign rb = DimW'(sum_y);

  assign wi        = hidx_q[4:1];
  assign len_new   = {data_byte_i, hdr_q[WLength][7:0]};
  assign rects_dec = rects_q - 16'd1;
  assign asm_new   = (pbc_q == 2'd3) ? asm_q : (asm_q | (24'(data_byte_i) << {pbc_q, 3'b000}));
  assign pix_v     = asm_new[15:0];

  always_comb begin
    phase_d   = phase_q;
    rects_d   = rects_q;
    hdr_d     = hdr_q;
    hidx_d    = hidx_q;
    left_d    = left_q;
    col_d     = col_q;
    row_d     = row_q;
    asm_d     = asm_q;
    pbc_d     = pbc_q;
    bnd_d     = bnd_q;
    seen_d    = seen_q;
    do_finish = 1'b0;
    res_o     = '0;

    case (phase_q)
      PH_COUNT: begin
        if (!hidx_q[0]) begin
          rects_d = {8'h00, data_byte_i};
          hidx_d  = 5'd1;
        end else begin
          rects_d = {data_byte_i, rects_q[7:0]};
          hidx_d  = 5'd0;
          phase_d = (rects_d != 16'd0) ? PH_HEADER : PH_DONE;
        end
      end
      PH_HEADER: begin
        hdr_d[wi] = hidx_q[0] ? {data_byte_i, hdr_q[wi][7:0]} : {8'h00, data_byte_i};
        if (hidx_q == 5'(HdrLast)) begin
          hidx_d = 5'd0;
          left_d = len_new;
          col_d  = '0;
          row_d  = '0;
          asm_d  = '0;
          pbc_d  = '0;
          if (len_new == 16'd0) do_finish = 1'b1;
          else                  phase_d   = PH_BITMAP;
        end else begin
          hidx_d = hidx_q + 5'd1;
        end
      end
      PH_BITMAP: begin
        left_d = left_q - 16'd1;
        if (rect_ok) begin
          if ({1'b0, pbc_q} + 3'd1 >= bpp_bytes) begin
            if ((hdr_q[WWidth] != 16'd0) && (row_q < hdr_q[WHeight])) begin
              res_o.pix_vld     = 1'b1;
              res_o.pix.kind    = KIND_PIXEL;
              res_o.pix.pixel_x = hdr_q[WLeft][12:0] + col_q[12:0];
              res_o.pix.pixel_y = hdr_q[WTop][12:0] + hdr_q[WHeight][12:0] - 13'd1
                                  - row_q[12:0];
              if (bpp_bytes == 3'd2) begin
                res_o.pix.red   = scale5(pix_v[15:11]);
                res_o.pix.green = scale6(pix_v[10:5]);
                res_o.pix.blue  = scale5(pix_v[4:0]);
              end else begin
                res_o.pix.red   = asm_new[23:16];
                res_o.pix.green = asm_new[15:8];
                res_o.pix.blue  = asm_new[7:0];
              end
              if ({1'b0, col_q} + 17'd1 >= {1'b0, hdr_q[WWidth]}) begin
                col_d = '0;
                row_d = row_q + 16'd1;
              end else begin
                col_d = col_q + 16'd1;
              end
            end
            pbc_d = '0;
            asm_d = '0;
          end else begin
            pbc_d = pbc_q + 2'd1;
            asm_d = asm_new;
          end
        end
        if (left_d == 16'd0) do_finish = 1'b1;
      end
      PH_DONE: begin
        // trailing bytes are dropped
      end
      default: begin
        phase_d = PH_COUNT;
      end
    endcase

    if (do_finish) begin
      if (rect_ok && !(hdr_q[WWidth] == 16'd0 && hdr_q[WHeight] == 16'd0)) begin
        seen_d = 1'b1;
        if (!seen_q) begin
          bnd_d[0] = rl;
          bnd_d[1] = rt;
          bnd_d[2] = rr;
          bnd_d[3] = rb;
        end else begin
          if (rl < bnd_q[0]) bnd_d[0] = rl;
          if (rt < bnd_q[1]) bnd_d[1] = rt;
          if (rr > bnd_q[2]) bnd_d[2] = rr;
          if (rb > bnd_q[3]) bnd_d[3] = rb;
        end
      end
      rects_d = rects_dec;
      phase_d = (rects_dec != 16'd0) ? PH_HEADER : PH_DONE;
    end

    res_o.pix.end_of_run = !final_byte_i;

    if (final_byte_i) begin
      res_o.fin_vld        = 1'b1;
      res_o.fin.end_of_run = 1'b1;
      if (phase_d == PH_DONE) begin
        res_o.fin.kind = KIND_DONE;
        if (seen_d) begin
          res_o.fin.dirty_valid  = 1'b1;
          res_o.fin.dirty_left   = 14'(bnd_d[0]);
          res_o.fin.dirty_top    = 14'(bnd_d[1]);
          res_o.fin.dirty_right  = 14'(bnd_d[2]);
          res_o.fin.dirty_bottom = 14'(bnd_d[3]);
        end
      end else begin
        res_o.fin.kind = KIND_TRUNC;
      end
      // rearm for the next update
      phase_d = PH_COUNT;
      rects_d = '0;
      hidx_d  = '0;
      left_d  = '0;
      col_d   = '0;
      row_d   = '0;
      asm_d   = '0;
      pbc_d   = '0;
      bnd_d   = '{default: '0};
      seen_d  = 1'b0;
    end

    if (!acc_i) begin
      res_o.pix_vld = 1'b0;
      res_o.fin_vld = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_COUNT;
      rects_q <= '0;
      hidx_q  <= '0;
      left_q  <= '0;
      col_q   <= '0;
      row_q   <= '0;
      asm_q   <= '0;
      pbc_q   <= '0;
      bnd_q   <= '{default: '0};
      seen_q  <= 1'b0;
    end else if (acc_i) begin
      phase_q <= phase_d;
      rects_q <= rects_d;
      hidx_q  <= hidx_d;
      left_q  <= left_d;
      col_q   <= col_d;
      row_q   <= row_d;
      asm_q   <= asm_d;
      pbc_q   <= pbc_d;
      bnd_q   <= bnd_d;
      seen_q  <= seen_d;
    end
  end

  // header words hold garbage until written
  always_ff @(posedge clk_i) begin
    if (acc_i) hdr_q <= hdr_d;
  end

  a_bitmap_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BITMAP) |-> (left_q != 16'd0))
    else $error("bitmap phase with no bytes left");

  a_hidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == PH_COUNT) |-> (hidx_q < 5'd2)) and
    ((phase_q == PH_HEADER) |-> (hidx_q <= 5'(HdrLast))))
    else $error("header byte index out of range");

  a_done_no_rects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE) |-> (rects_q == 16'd0))
    else $error("done with rectangles remaining");

endmodule

### rtl/bupd_result_queue.sv
module bupd_result_queue import bupd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_pair_t push_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output res_t      head_o
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  res_t            mem [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   count_q, count_d;
  logic            pop;
  logic [PtrW:0]   n_push;
  logic [PtrW-1:0] fin_addr;

  assign n_push   = (PtrW + 1)'(push_i.pix_vld) + (PtrW + 1)'(push_i.fin_vld);
  assign pop      = out_valid_o && !out_stall_i;
  assign wr_d     = wr_q + PtrW'(n_push);
  assign rd_d     = rd_q + PtrW'(pop);
  assign count_d  = count_q + n_push - (PtrW + 1)'(pop);
  assign fin_addr = wr_q + PtrW'(push_i.pix_vld);

  // room for two results must be there before a byte is taken
  assign full_o      = count_q > (PtrW + 1)'(Depth - 2);
  assign out_valid_o = count_q != '0;
  assign head_o      = mem[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.pix_vld) mem[wr_q] <= push_i.pix;
    if (push_i.fin_vld) mem[fin_addr] <= push_i.fin;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PtrW + 1)'(Depth))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.pix_vld || push_i.fin_vld) |-> !full_o)
    else $error("push into full result queue");

  a_eor_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.fin_vld |-> push_i.fin.end_of_run)
    else $error("end report without end_of_run");

endmodule

### rtl/bitmap_update_rect_decoder.sv
// Channel    | Direction | Handshake                | Payload
// -----------+-----------+--------------------------+--------------------------------------
// byte in    | input     | in_valid_i / in_stall_o  | data_byte_i, final_byte_i
// result out | output    | out_valid_o / out_stall_i| kind_o, pixel_x/y_o, red/green/blue_o,
//            |           |                          | dirty_*_o, end_of_run_o
// config     | APB       | psel/penable/pwrite      | paddr, pwdata, prdata
//
// One byte is taken per cycle unless in_stall_o is high; results are registered in a queue.
// A byte causes at most two items (a pixel write and an end report); a four-entry
// result queue absorbs them, and in_stall_o rises while it holds three or more.
// Reset (rst_ni low, async) sets frame size to 640x480 and the parser to waiting
// for the rectangle count; no clearing pass is needed.
// Output stalls back up into the queue and from there into the input stall.
module bitmap_update_rect_decoder import bupd_pkg::*; #(
  parameter int MAX_FRAME_DIM = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,

  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [12:0] pixel_x_o,
  output logic [12:0] pixel_y_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic        dirty_valid_o,
  output logic [13:0] dirty_left_o,
  output logic [13:0] dirty_top_o,
  output logic [13:0] dirty_right_o,
  output logic [13:0] dirty_bottom_o,
  output logic        end_of_run_o
);

  localparam int DimW = $clog2(MAX_FRAME_DIM + 1);
  localparam int CmpW = (DimW > 14) ? DimW : 14;

  logic [13:0]     frame_w_q, frame_h_q;
  logic            cfg_wr;
  logic            reg_sel;
  logic [DimW-1:0] fw_clamped, fh_clamped;
  logic            in_acc;
  res_pair_t       pair;
  res_t            head;
  logic            q_full;

  // config registers; index is the word address
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_w_q <= 14'(FRAME_W_RESET);
      frame_h_q <= 14'(FRAME_H_RESET);
    end else if (cfg_wr) begin
      if (reg_sel == 1'(REG_FRAME_WIDTH)) frame_w_q <= pwdata[13:0];
      else                                frame_h_q <= pwdata[13:0];
    end
  end

  assign prdata = (reg_sel == 1'(REG_FRAME_HEIGHT)) ? 32'(frame_h_q) : 32'(frame_w_q);

  // frame size as used for rectangle fit: clamped to min..MAX_FRAME_DIM
  always_comb begin
    if (CmpW'(frame_w_q) < CmpW'(FRAME_W_MIN))        fw_clamped = DimW'(FRAME_W_MIN);
    else if (CmpW'(frame_w_q) > CmpW'(MAX_FRAME_DIM)) fw_clamped = DimW'(MAX_FRAME_DIM);
    else                                              fw_clamped = DimW'(frame_w_q);
    if (CmpW'(frame_h_q) < CmpW'(FRAME_H_MIN))        fh_clamped = DimW'(FRAME_H_MIN);
    else if (CmpW'(frame_h_q) > CmpW'(MAX_FRAME_DIM)) fh_clamped = DimW'(MAX_FRAME_DIM);
    else                                              fh_clamped = DimW'(frame_h_q);
  end

  assign in_stall_o = q_full;
  assign in_acc     = in_valid_i && !in_stall_o;

  bupd_parser #(
    .MAX_FRAME_DIM(MAX_FRAME_DIM)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (in_acc),
    .data_byte_i (data_byte_i),
    .final_byte_i(final_byte_i),
    .frame_w_i   (fw_clamped),
    .frame_h_i   (fh_clamped),
    .res_o       (pair)
  );

  bupd_result_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (pair),
    .full_o     (q_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .head_o     (head)
  );

  assign kind_o         = head.kind;
  assign pixel_x_o      = head.pixel_x;
  assign pixel_y_o      = head.pixel_y;
  assign red_o          = head.red;
  assign green_o        = head.green;
  assign blue_o         = head.blue;
  assign dirty_valid_o  = head.dirty_valid;
  assign dirty_left_o   = head.dirty_left;
  assign dirty_top_o    = head.dirty_top;
  assign dirty_right_o  = head.dirty_right;
  assign dirty_bottom_o = head.dirty_bottom;
  assign end_of_run_o   = head.end_of_run;

endmodule

### sim/bupd_result_checker.sv
module bupd_result_checker import bupd_pkg::*; #(
  parameter int MAX_FRAME_DIM = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,

  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,

  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [1:0]  kind_o,
  input  logic [12:0] pixel_x_o,
  input  logic [12:0] pixel_y_o,
  input  logic [7:0]  red_o,
  input  logic [7:0]  green_o,
  input  logic [7:0]  blue_o,
  input  logic        dirty_valid_o,
  input  logic [13:0] dirty_left_o,
  input  logic [13:0] dirty_top_o,
  input  logic [13:0] dirty_right_o,
  input  logic [13:0] dirty_bottom_o,
  input  logic        end_of_run_o,

  output int          mismatches,
  output int          ops_outstanding
);

  typedef enum logic [2:0] {AWAIT_COUNT, IN_HEADER, IN_BITMAP, RECTS_DONE} parse_e;

  // header word slots
  localparam int W_LEFT   = 0;
  localparam int W_TOP    = 1;
  localparam int W_WIDTH  = 4;
  localparam int W_HEIGHT = 5;
  localparam int W_BPP    = 6;
  localparam int W_FLAGS  = 7;
  localparam int W_LENGTH = 8;

  res_t        fb_ops_due[$];
  res_t        want;

  parse_e      phase;
  logic [15:0] rects_left;
  logic [15:0] hdr[9];
  logic [4:0]  hdr_idx;
  logic [15:0] bytes_left;
  logic [15:0] col;
  logic [15:0] row;
  logic [23:0] pix_acc;
  logic [1:0]  pix_cnt;
  logic [13:0] dirty_l, dirty_t, dirty_r, dirty_b;
  logic        dirty_seen;
  logic [13:0] frame_w, frame_h;

  function automatic int bytes_per_px(input logic [15:0] bpp);
    case (bpp)
      16'd16:  return 2;
      16'd24:  return 3;
      16'd32:  return 4;
      default: return 0;
    endcase
  endfunction

  function automatic int clamp_dim(input int v, input int lo);
    if (v < lo) return lo;
    if (v > MAX_FRAME_DIM) return MAX_FRAME_DIM;
    return v;
  endfunction

  function automatic bit rect_fits();
    if (hdr[W_FLAGS][0]) return 1'b0;
    if (bytes_per_px(hdr[W_BPP]) == 0) return 1'b0;
    if (int'(hdr[W_LEFT]) + int'(hdr[W_WIDTH]) > clamp_dim(int'(frame_w), FRAME_W_MIN))
      return 1'b0;
    if (int'(hdr[W_TOP]) + int'(hdr[W_HEIGHT]) > clamp_dim(int'(frame_h), FRAME_H_MIN))
      return 1'b0;
    return 1'b1;
  endfunction

  task automatic restart_update();
    phase      = AWAIT_COUNT;
    rects_left = '0;
    foreach (hdr[i]) hdr[i] = '0;
    hdr_idx    = '0;
    bytes_left = '0;
    col        = '0;
    row        = '0;
    pix_acc    = '0;
    pix_cnt    = '0;
    dirty_l    = '0;
    dirty_t    = '0;
    dirty_r    = '0;
    dirty_b    = '0;
    dirty_seen = 1'b0;
  endtask

  // end of a rectangle: grow the union, move on
  task automatic close_rect();
    int l, t, r, b;
    l = int'(hdr[W_LEFT]);
    t = int'(hdr[W_TOP]);
    r = l + int'(hdr[W_WIDTH]);
    b = t + int'(hdr[W_HEIGHT]);
    if (rect_fits() && (hdr[W_WIDTH] != 0 || hdr[W_HEIGHT] != 0)) begin
      if (!dirty_seen) begin
        dirty_l = 14'(l);
        dirty_t = 14'(t);
        dirty_r = 14'(r);
        dirty_b = 14'(b);
        dirty_seen = 1'b1;
      end else begin
        if (l < int'(dirty_l)) dirty_l = 14'(l);
        if (t < int'(dirty_t)) dirty_t = 14'(t);
        if (r > int'(dirty_r)) dirty_r = 14'(r);
        if (b > int'(dirty_b)) dirty_b = 14'(b);
      end
    end
    rects_left = rects_left - 16'd1;
    phase = (rects_left != 0) ? IN_HEADER : RECTS_DONE;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic fin);
    res_t        made[2];
    int          n, bpb, w, h;
    logic [31:0] y;
    n = 0;
    made[0] = '0;
    made[1] = '0;
    case (phase)
      AWAIT_COUNT: begin
        if (hdr_idx == 0) rects_left = {8'h00, b};
        else rects_left = rects_left | {b, 8'h00};
        hdr_idx++;
        if (hdr_idx >= 2) begin
          hdr_idx = '0;
          phase = (rects_left != 0) ? IN_HEADER : RECTS_DONE;
        end
      end
      IN_HEADER: begin
        if (hdr_idx[0]) hdr[hdr_idx >> 1] = hdr[hdr_idx >> 1] | {b, 8'h00};
        else hdr[hdr_idx >> 1] = {8'h00, b};
        hdr_idx++;
        if (hdr_idx >= 18) begin
          hdr_idx    = '0;
          bytes_left = hdr[W_LENGTH];
          col        = '0;
          row        = '0;
          pix_acc    = '0;
          pix_cnt    = '0;
          if (bytes_left == 0) close_rect();
          else phase = IN_BITMAP;
        end
      end
      IN_BITMAP: begin
        bytes_left = bytes_left - 16'd1;
        if (rect_fits()) begin
          bpb = bytes_per_px(hdr[W_BPP]);
          w   = int'(hdr[W_WIDTH]);
          h   = int'(hdr[W_HEIGHT]);
          if (pix_cnt < 3) pix_acc = pix_acc | (24'(b) << (8 * pix_cnt));
          if (int'(pix_cnt) + 1 >= bpb) begin
            // pixels past the last row are dropped
            if (w != 0 && int'(row) < h) begin
              made[0].kind    = KIND_PIXEL;
              made[0].pixel_x = 13'(hdr[W_LEFT] + col);
              y = 32'(hdr[W_TOP]) + 32'(h) - 32'd1 - 32'(row);
              made[0].pixel_y = y[12:0];
              if (bpb == 2) begin
                made[0].red   = 8'(int'(pix_acc[15:11]) * 255 / 31);
                made[0].green = 8'(int'(pix_acc[10:5]) * 255 / 63);
                made[0].blue  = 8'(int'(pix_acc[4:0]) * 255 / 31);
              end else begin
                made[0].red   = pix_acc[23:16];
                made[0].green = pix_acc[15:8];
                made[0].blue  = pix_acc[7:0];
              end
              n = 1;
              col++;
              if (int'(col) >= w) begin
                col = '0;
                row++;
              end
            end
            pix_cnt = '0;
            pix_acc = '0;
          end else begin
            pix_cnt++;
          end
        end
        if (bytes_left == 0) close_rect();
      end
      default: ;
    endcase

    if (fin) begin
      if (phase == RECTS_DONE) begin
        made[n].kind = KIND_DONE;
        if (dirty_seen) begin
          made[n].dirty_valid  = 1'b1;
          made[n].dirty_left   = dirty_l;
          made[n].dirty_top    = dirty_t;
          made[n].dirty_right  = dirty_r;
          made[n].dirty_bottom = dirty_b;
        end
      end else begin
        made[n].kind = KIND_TRUNC;
      end
      n++;
      restart_update();
    end

    if (n > 0) made[n-1].end_of_run = 1'b1;
    for (int i = 0; i < n; i++) fb_ops_due.push_back(made[i]);
  endtask

  task automatic match_field(input string what, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s expected %0d got %0d", $time, what, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_w = 14'(FRAME_W_RESET);
      frame_h = 14'(FRAME_H_RESET);
      restart_update();
      fb_ops_due.delete();
      mismatches = 0;
      ops_outstanding = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == 3'(REG_FRAME_WIDTH * 4)) frame_w = pwdata[13:0];
        else if (paddr == 3'(REG_FRAME_HEIGHT * 4)) frame_h = pwdata[13:0];
      end

      if (in_valid_i && !in_stall_o) decode_byte(data_byte_i, final_byte_i);

      if (out_valid_o && !out_stall_i) begin
        if (fb_ops_due.size() == 0) begin
          $display("%0t: expected no result, got kind %0d x %0d y %0d", $time,
                   kind_o, pixel_x_o, pixel_y_o);
          mismatches++;
        end else begin
          want = fb_ops_due.pop_front();
          match_field("kind", 16'(want.kind), 16'(kind_o));
          match_field("pixel_x", 16'(want.pixel_x), 16'(pixel_x_o));
          match_field("pixel_y", 16'(want.pixel_y), 16'(pixel_y_o));
          match_field("red", 16'(want.red), 16'(red_o));
          match_field("green", 16'(want.green), 16'(green_o));
          match_field("blue", 16'(want.blue), 16'(blue_o));
          match_field("dirty_valid", 16'(want.dirty_valid), 16'(dirty_valid_o));
          match_field("dirty_left", 16'(want.dirty_left), 16'(dirty_left_o));
          match_field("dirty_top", 16'(want.dirty_top), 16'(dirty_top_o));
          match_field("dirty_right", 16'(want.dirty_right), 16'(dirty_right_o));
          match_field("dirty_bottom", 16'(want.dirty_bottom), 16'(dirty_bottom_o));
          match_field("end_of_run", 16'(want.end_of_run), 16'(end_of_run_o));
        end
      end

      ops_outstanding = fb_ops_due.size();
    end
  end

endmodule

### sim/bitmap_update_rect_decoder_test.sv
module bitmap_update_rect_decoder_test;
  import bupd_pkg::*;

  localparam int MAX_DIM      = 8192;
  localparam int CYCLE_LIMIT  = 400000;  // far above the slowest legal run
  localparam int ITEMS_TARGET = 1750;    // random bytes over all frame settings
  localparam int N_PHASES     = 6;
  localparam int DRAIN_CYCLES = 8;       // idle wait after the last owed result is out

  // how pixel bytes of a rectangle are filled
  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_e;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;

  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [2:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i  = '0;
  logic        final_byte_i = 1'b0;

  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [1:0]  kind_o;
  logic [12:0] pixel_x_o;
  logic [12:0] pixel_y_o;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic        dirty_valid_o;
  logic [13:0] dirty_left_o;
  logic [13:0] dirty_top_o;
  logic [13:0] dirty_right_o;
  logic [13:0] dirty_bottom_o;
  logic        end_of_run_o;

  int          mismatches;
  int          ops_outstanding;

  int          cycles     = 0;
  int          burst_left = 0;   // bytes left in the current sender burst
  int          gap_style  = 1;   // 0 back to back, 1 short gaps, 2 long gaps
  int          bytes_sent = 0;
  int          fw_eff     = FRAME_W_RESET;
  int          fh_eff     = FRAME_H_RESET;
  logic [7:0]  upd_bytes[$];     // bytes of the update under construction

  bitmap_update_rect_decoder #(.MAX_FRAME_DIM(MAX_DIM)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .final_byte_i   (final_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .dirty_valid_o  (dirty_valid_o),
    .dirty_left_o   (dirty_left_o),
    .dirty_top_o    (dirty_top_o),
    .dirty_right_o  (dirty_right_o),
    .dirty_bottom_o (dirty_bottom_o),
    .end_of_run_o   (end_of_run_o)
  );

  bupd_result_checker #(.MAX_FRAME_DIM(MAX_DIM)) result_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .final_byte_i    (final_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o),
    .dirty_valid_o   (dirty_valid_o),
    .dirty_left_o    (dirty_left_o),
    .dirty_top_o     (dirty_top_o),
    .dirty_right_o   (dirty_right_o),
    .dirty_bottom_o  (dirty_bottom_o),
    .end_of_run_o    (end_of_run_o),
    .mismatches      (mismatches),
    .ops_outstanding (ops_outstanding)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("bitmap_update_rect_decoder_test failed");
    $finish;
  end

  // Output back-pressure: the mode changes after each random span, from no
  // stalls at all to stalling most of the time.
  initial begin
    int mode, span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(50, 300);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 1) == 1);
          2:       out_stall_i <= ($urandom_range(0, 7) == 0);
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // APB write: setup cycle, then access cycle until pready.
  // Called at a falling edge, returns at one.
  task automatic reg_write(input int idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx * 4);
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drive one byte and hold it until taken. The sender runs in bursts; a gap
  // only lowers valid when its length is not zero, so valid never drops
  // and rises within the same step.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_style == 0) ? 0 : $urandom_range(0, (gap_style == 1) ? 3 : 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    final_byte_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    burst_left--;
    bytes_sent++;
  endtask

  // send the built update, final mark on its last byte
  task automatic send_update();
    for (int i = 0; i < upd_bytes.size(); i++)
      send_byte(upd_bytes[i], i == upd_bytes.size() - 1);
    upd_bytes.delete();
  endtask

  task automatic put16(input logic [15:0] v);
    upd_bytes.push_back(v[7:0]);
    upd_bytes.push_back(v[15:8]);
  endtask

  // Header: left, top, right, bottom, width, height, bpp, flags, length.
  // Right and bottom are not used by the decoder, so they carry noise.
  task automatic put_rect(input int l, input int t, input int w, input int h,
                          input int bpp, input int flags, input int len, input fill_e fill);
    put16(16'(l));
    put16(16'(t));
    put16(16'($urandom));
    put16(16'($urandom));
    put16(16'(w));
    put16(16'(h));
    put16(16'(bpp));
    put16(16'(flags));
    put16(16'(len));
    repeat (len) begin
      case (fill)
        FILL_ONES:  upd_bytes.push_back(8'hFF);
        FILL_ZEROS: upd_bytes.push_back(8'h00);
        default:    upd_bytes.push_back(8'($urandom));
      endcase
    end
  endtask

  // Rectangle origin along one axis: mostly inside, often flush with the far
  // edge or one past it, now and then anywhere in 16 bits.
  function automatic int pick_pos(input int dim, input int size);
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 65535);
      1:       return dim - size + 1;
      2, 3:    return dim - size;
      4, 5:    return $urandom_range(0, 15);
      default: return $urandom_range(0, dim - size);
    endcase
  endfunction

  // Small rectangles keep bitmaps short; most are well formed, some are
  // compressed, of odd depth, off the frame, short, long or empty.
  task automatic add_random_rect();
    int w, h, bpp, bpb, flags, l, t, len, nominal;
    fill_e fill;
    w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
    h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
    case ($urandom_range(0, 19))
      0:       bpp = $urandom_range(0, 65535);
      1:       bpp = 8;
      2:       bpp = 15;
      default: bpp = 8 * $urandom_range(2, 4);
    endcase
    flags = $urandom_range(0, 65535);
    if ($urandom_range(0, 7) != 0) flags = flags & 32'hFFFE;
    l = pick_pos(fw_eff, w);
    t = pick_pos(fh_eff, h);
    bpb = (bpp == 16) ? 2 : (bpp == 32) ? 4 : 3;
    nominal = w * h * bpb;
    case ($urandom_range(0, 9))
      0:       len = 0;
      1:       len = (nominal > 0) ? $urandom_range(0, nominal - 1) : 0;
      2:       len = nominal + $urandom_range(1, 5);
      3:       len = $urandom_range(1, 16);
      default: len = nominal;
    endcase
    case ($urandom_range(0, 15))
      0:       fill = FILL_ONES;
      1:       fill = FILL_ZEROS;
      default: fill = FILL_RANDOM;
    endcase
    put_rect(l, t, w, h, bpp, flags, len, fill);
  endtask

  // One update: count, rectangles, maybe trailing noise, maybe cut short.
  // The announced count sometimes disagrees with what follows.
  task automatic add_random_update();
    int nrect, count, keep;
    gap_style = $urandom_range(0, 2);
    nrect = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
    case ($urandom_range(0, 11))
      0:       count = nrect + 1;
      1:       count = (nrect > 0) ? nrect - 1 : 0;
      2:       count = $urandom_range(0, 65535);
      default: count = nrect;
    endcase
    put16(16'(count));
    repeat (nrect) add_random_rect();
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 4)) upd_bytes.push_back(8'($urandom));
    if ($urandom_range(0, 9) == 0) begin
      keep = $urandom_range(1, upd_bytes.size());
      while (upd_bytes.size() > keep) void'(upd_bytes.pop_back());
    end
    send_update();
  endtask

  // Stop sending and let every owed result come out before touching registers.
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (ops_outstanding != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    int fw_set[N_PHASES];
    int fh_set[N_PHASES];

    // reset values first, then below minimum, the maximum, all ones,
    // somewhere in between, and just off the minimum
    fw_set = '{FRAME_W_RESET, 0, MAX_DIM, 16383, $urandom_range(FRAME_W_MIN, MAX_DIM), 641};
    fh_set = '{FRAME_H_RESET, 0, MAX_DIM, 16383, $urandom_range(FRAME_H_MIN, MAX_DIM), 479};

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // --- directed part, 640x480 frame ---

    // zero count: complete right after the count
    put16(16'd0);
    send_update();

    // final on the first count byte: truncated
    upd_bytes.push_back(8'hA5);
    send_update();

    // every pixel format and every skip rule in one update
    put16(16'd8);
    put_rect(638, 478, 2, 2, 16, 0, 8, FILL_ZEROS);         // flush with the far corner
    put_rect(10, 20, 3, 2, 24, 0, 14, FILL_RANDOM);         // short bitmap
    put_rect(0, 0, 1, 2, 32, 16'hFFFE, 11, FILL_ONES);      // extra bytes, flags set
    put_rect(600, 400, 0, 0, 16, 0, 0, FILL_RANDOM);        // empty, stays out of union
    put_rect(5, 5, 0, 3, 24, 0, 0, FILL_RANDOM);            // zero width still counts
    put_rect(1, 1, 1, 1, 16, 1, 2, FILL_ONES);              // compressed
    put_rect(2, 2, 1, 1, 8, 0, 3, FILL_ONES);               // unsupported depth
    put_rect(639, 0, 2, 1, 16, 0, 4, FILL_ONES);            // one column past the frame
    upd_bytes.push_back(8'h5A);                             // trailing noise
    upd_bytes.push_back(8'hC3);
    send_update();

    // truncated inside a bitmap, after two pixels were written
    put16(16'd1);
    put_rect(100, 100, 4, 1, 16, 0, 8, FILL_ONES);
    repeat (4) void'(upd_bytes.pop_back());
    send_update();

    // --- random part, one phase per frame setting ---
    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      if (p > 0) begin
        reg_write(REG_FRAME_WIDTH, 32'(fw_set[p]));
        reg_write(REG_FRAME_HEIGHT, 32'(fh_set[p]));
      end
      fw_eff = (fw_set[p] < FRAME_W_MIN) ? FRAME_W_MIN :
               (fw_set[p] > MAX_DIM) ? MAX_DIM : fw_set[p];
      fh_eff = (fh_set[p] < FRAME_H_MIN) ? FRAME_H_MIN :
               (fh_set[p] > MAX_DIM) ? MAX_DIM : fh_set[p];
      bytes_sent = 0;
      while (bytes_sent < ITEMS_TARGET / N_PHASES) add_random_update();
    end

    drain();
    if (mismatches == 0) begin
      $display("bitmap_update_rect_decoder_test passed");
    end else begin
      $display("bitmap_update_rect_decoder_test failed");
    end
    $finish;
  end

endmodule
